// ----- hw/rtl/fsb_pkg.sv -----
package fsb_pkg;

  // Register width and derived fixed-point widths
  localparam int RADIUS_W  = 14;
  localparam int SQ_W      = 2 * RADIUS_W;   // squared radius, 1/256 pixel^2
  localparam int ROOT_W    = RADIUS_W + 8;   // distance in 1/4096 pixel
  localparam int DEN_W     = RADIUS_W + 8;   // blend denominator
  localparam int RES_W     = 16;             // result channel width
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INNER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATHER = 2'd1;

  typedef logic [1:0] region_t;

  // Region codes
  localparam region_t REGION_PASS  = 2'd0;
  localparam region_t REGION_COPY  = 2'd1;
  localparam region_t REGION_BLEND = 2'd2;

endpackage

// ----- hw/rtl/fsb_cfg_if.sv -----
interface fsb_cfg_if import fsb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RADIUS_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fsb_pixel_if.sv -----
interface fsb_pixel_if #(
  parameter int OW = 11,
  parameter int CB = 16
);
  logic          valid;
  logic          ready;
  logic [OW-1:0] offset_x;
  logic [OW-1:0] offset_y;
  logic [CB-1:0] source_red;
  logic [CB-1:0] source_green;
  logic [CB-1:0] source_blue;
  logic [CB-1:0] target_red;
  logic [CB-1:0] target_green;
  logic [CB-1:0] target_blue;

  modport source (output valid, offset_x, offset_y, source_red, source_green, source_blue,
                  target_red, target_green, target_blue, input ready);
  modport sink   (input valid, offset_x, offset_y, source_red, source_green, source_blue,
                  target_red, target_green, target_blue, output ready);
endinterface

// ----- hw/rtl/fsb_result_if.sv -----
interface fsb_result_if import fsb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_red;
  logic [RES_W-1:0] result_green;
  logic [RES_W-1:0] result_blue;
  region_t          region_code;

  modport source (output valid, result_red, result_green, result_blue, region_code,
                  input ready);
  modport sink   (input valid, result_red, result_green, result_blue, region_code,
                  output ready);
endinterface

// ----- hw/rtl/fsb_geom.sv -----
module fsb_geom import fsb_pkg::*; #(
  parameter int OW = 11,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [OW-1:0]       ox,
  input  logic [OW-1:0]       oy,
  input  logic [SW-1:0]       side_in,
  input  logic [RADIUS_W-1:0] feather,
  input  logic [SQ_W-1:0]     fsq,
  input  logic [SQ_W-1:0]     rsq,
  output logic                out_valid,
  output logic [SQ_W-1:0]     rad,
  output region_t             region,
  output logic [SW-1:0]       side_out
);

  localparam int PW  = OW + 4;
  localparam int DW  = (PW > RADIUS_W) ? PW : RADIUS_W;
  localparam int D2W = 2 * DW + 1;

  logic [DW-1:0]     posx, posy, fx, dx_next, dy_next;
  logic [DW-1:0]     dx, dy;
  logic [2*DW-1:0]   sqx, sqy;
  logic [D2W-1:0]    d2;
  logic              v1, v2;
  logic [SW-1:0]     s1, s2;
  region_t           region_next;

  // Take the absolute axis distances from the centre
  always_comb begin
    posx    = DW'({ox, 4'b0000});
    posy    = DW'({oy, 4'b0000});
    fx      = DW'(feather);
    dx_next = (posx >= fx) ? (posx - fx) : (fx - posx);
    dy_next = (posy >= fx) ? (posy - fx) : (fx - posy);
  end

  // Classify the squared distance against both radii
  always_comb begin
    d2 = D2W'(sqx) + D2W'(sqy);
    if (d2 >= D2W'(fsq)) begin
      region_next = REGION_PASS;
    end else if (d2 <= D2W'(rsq)) begin
      region_next = REGION_COPY;
    end else begin
      region_next = REGION_BLEND;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      dx       <= dx_next;
      dy       <= dy_next;
      s1       <= side_in;
      sqx      <= dx * dx;
      sqy      <= dy * dy;
      s2       <= s1;
      rad      <= d2[SQ_W-1:0];
      region   <= region_next;
      side_out <= s2;
    end
  end

endmodule

// ----- hw/rtl/fsb_sqrt.sv -----
module fsb_sqrt import fsb_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   rad,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SW-1:0]     side_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int FRAC  = RAD_W - SQ_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld   [ROOT_W];
  logic [RAD_W-1:0]  radp  [ROOT_W];
  logic [REM_W-1:0]  rem   [ROOT_W];
  logic [ROOT_W-1:0] rootp [ROOT_W];
  logic [SW-1:0]     side  [ROOT_W];

  // One root bit per stage, restoring method
  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              vld_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i, remsh, trial;
    logic [ROOT_W-1:0] root_i;
    logic [SW-1:0]     side_i;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rad_i  = {rad, {FRAC{1'b0}}};
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_rest
      assign vld_i  = vld[k-1];
      assign rad_i  = radp[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = rootp[k-1];
      assign side_i = side[k-1];
    end

    always_comb begin
      remsh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial = {root_i, 2'b01};
      ge    = (remsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        radp[k]  <= rad_i << 2;
        rem[k]   <= ge ? (remsh - trial) : remsh;
        rootp[k] <= {root_i[ROOT_W-2:0], ge};
        side[k]  <= side_i;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rootp[ROOT_W-1];
  assign side_out  = side[ROOT_W-1];

endmodule

// ----- hw/rtl/fsb_weight.sv -----
module fsb_weight import fsb_pkg::*; #(
  parameter int CB = 16,
  parameter int SW = 2 + 6 * CB
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [ROOT_W-1:0]       root,
  input  logic [SW-1:0]           side_in,
  input  logic [RADIUS_W-1:0]     feather,
  input  logic [RADIUS_W-1:0]     inner,
  output logic                    out_valid,
  output logic [CB+DEN_W:0]       v [3],
  output logic [DEN_W-1:0]        den,
  output logic [SW-1:0]           side_out
);

  localparam int MW = CB + DEN_W;
  localparam int VW = CB + DEN_W + 1;

  logic [DEN_W-1:0] top, num0, num_next, den_next;
  logic [DEN_W-1:0] num1, den1, den2;
  logic [MW-1:0]    pa [3];
  logic [MW-1:0]    pb [3];
  logic [SW-1:0]    s1, s2;
  logic             v1, v2;

  function automatic logic [CB-1:0] side_in_src(input logic [SW-1:0] s, input int k);
    side_in_src = s[2 + k*CB +: CB];
  endfunction

  function automatic logic [CB-1:0] side_in_dst(input logic [SW-1:0] s, input int k);
    side_in_dst = s[2 + (3+k)*CB +: CB];
  endfunction

  // Form the opacity numerator and denominator
  always_comb begin
    top      = DEN_W'({feather, 8'h00});
    num0     = (top > DEN_W'(root)) ? (top - DEN_W'(root)) : '0;
    den_next = (feather > inner) ? DEN_W'({feather - inner, 8'h00}) : DEN_W'(1);
    num_next = (num0 > den_next) ? den_next : num0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Weight both pixels, then add the rounding half
  always_ff @(posedge clk) begin
    if (en) begin
      num1     <= num_next;
      den1     <= den_next;
      s1       <= side_in;
      den2     <= den1;
      s2       <= s1;
      den      <= den2;
      side_out <= s2;
      for (int k = 0; k < 3; k++) begin
        pa[k] <= MW'(side_in_dst(s1, k)) * MW'(den1 - num1);
        pb[k] <= MW'(side_in_src(s1, k)) * MW'(num1);
        v[k]  <= VW'(pa[k]) + VW'(pb[k]) + VW'(den2 >> 1);
      end
    end
  end

endmodule

// ----- hw/rtl/fsb_div.sv -----
module fsb_div import fsb_pkg::*; #(
  parameter int CB = 16,
  parameter int SW = 2 + 6 * CB
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [CB+DEN_W:0] v [3],
  input  logic [DEN_W-1:0]  den,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [CB-1:0]     q [3],
  output logic [SW-1:0]     side_out
);

  localparam int VW    = CB + DEN_W + 1;
  localparam int REM_W = DEN_W + 1;

  logic             vld  [CB];
  logic [DEN_W-1:0] denp [CB];
  logic [SW-1:0]    side [CB];
  logic [REM_W-1:0] rem  [CB][3];
  logic [CB-1:0]    low  [CB][3];
  logic [CB-1:0]    quo  [CB][3];

  // One quotient bit per stage on three lanes
  for (genvar k = 0; k < CB; k++) begin : g_st
    logic             vld_i;
    logic [DEN_W-1:0] den_i;
    logic [SW-1:0]    side_i;
    logic [REM_W-1:0] rem_i [3];
    logic [REM_W-1:0] remsh [3];
    logic [CB-1:0]    low_i [3];
    logic [CB-1:0]    quo_i [3];
    logic             ge    [3];

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign den_i  = den;
      assign side_i = side_in;
      for (genvar c = 0; c < 3; c++) begin : g_ln
        assign rem_i[c] = v[c][VW-1:CB];
        assign low_i[c] = v[c][CB-1:0];
        assign quo_i[c] = '0;
      end
    end else begin : g_rest
      assign vld_i  = vld[k-1];
      assign den_i  = denp[k-1];
      assign side_i = side[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_ln
        assign rem_i[c] = rem[k-1][c];
        assign low_i[c] = low[k-1][c];
        assign quo_i[c] = quo[k-1][c];
      end
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        remsh[c] = {rem_i[c][DEN_W-1:0], low_i[c][CB-1]};
        ge[c]    = (remsh[c] >= {1'b0, den_i});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        denp[k] <= den_i;
        side[k] <= side_i;
        for (int c = 0; c < 3; c++) begin
          rem[k][c] <= ge[c] ? (remsh[c] - {1'b0, den_i}) : remsh[c];
          low[k][c] <= low_i[c] << 1;
          quo[k][c] <= {quo_i[c][CB-2:0], ge[c]};
        end
      end
    end
  end

  assign out_valid = vld[CB-1];
  assign side_out  = side[CB-1];
  for (genvar c = 0; c < 3; c++) begin : g_out
    assign q[c] = quo[CB-1][c];
  end

endmodule

// ----- hw/rtl/feathered_spot_blend_unit.sv -----
// Throughput: one pixel per cycle while the skid stage is not full; 3 distance stages,
// 22 square-root stages (one root bit each), 3 weighting stages, CHANNEL_BITS divider
// stages (one quotient bit each), one output.
// An output register and a one-entry skid stage; a stalled result holds the whole pipeline
// and the input once the skid stage fills.
// Reset (rst, synchronous, active high) clears all valid bits and both radius registers.
module feathered_spot_blend_unit import fsb_pkg::*; #(
  parameter int MAX_SPAN     = 2048,
  parameter int CHANNEL_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  fsb_cfg_if.sink      cfg,
  fsb_pixel_if.sink    pixel,
  fsb_result_if.source result
);

  localparam int OW = $clog2(MAX_SPAN);
  localparam int CB = CHANNEL_BITS;
  localparam int SW = 2 + 6 * CB;
  localparam int VW = CB + DEN_W + 1;

  logic [RADIUS_W-1:0] inner, feather;
  logic [SQ_W-1:0]     fsq, rsq;
  logic                en;
  logic [SW-1:0]       side_in, g_side, s_side, w_side, d_side;
  logic                g_valid, s_valid, w_valid, d_valid;
  logic [SQ_W-1:0]     g_rad;
  region_t             g_region;
  logic [ROOT_W-1:0]   s_root;
  logic [VW-1:0]       w_v [3];
  logic [DEN_W-1:0]    w_den;
  logic [CB-1:0]       d_q [3];
  logic [3*RES_W+1:0]  tail, out_data, skid_data;
  logic                out_valid, skid_valid;
  region_t             t_region;
  logic [RES_W-1:0]    t_chan [3];

  // Take register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner   <= '0;
      feather <= '0;
      fsq     <= '0;
      rsq     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INNER: begin
          inner <= cfg.data;
          rsq   <= SQ_W'(cfg.data) * SQ_W'(cfg.data);
        end
        REG_FEATHER: begin
          feather <= cfg.data;
          fsq     <= SQ_W'(cfg.data) * SQ_W'(cfg.data);
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the whole pipeline while the skid stage is full
  assign en          = !skid_valid;
  assign pixel.ready = en;

  assign side_in = {pixel.target_blue, pixel.target_green, pixel.target_red,
                    pixel.source_blue, pixel.source_green, pixel.source_red, 2'b00};

  fsb_geom #(.OW(OW), .SW(SW)) u_geom (
    .clk(clk), .rst(rst), .en(en), .in_valid(pixel.valid),
    .ox(pixel.offset_x), .oy(pixel.offset_y), .side_in(side_in),
    .feather(feather), .fsq(fsq), .rsq(rsq),
    .out_valid(g_valid), .rad(g_rad), .region(g_region), .side_out(g_side)
  );

  fsb_sqrt #(.SW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid), .rad(g_rad),
    .side_in({g_side[SW-1:2], g_region}),
    .out_valid(s_valid), .root(s_root), .side_out(s_side)
  );

  fsb_weight #(.CB(CB), .SW(SW)) u_weight (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .root(s_root),
    .side_in(s_side), .feather(feather), .inner(inner),
    .out_valid(w_valid), .v(w_v), .den(w_den), .side_out(w_side)
  );

  fsb_div #(.CB(CB), .SW(SW)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(w_valid), .v(w_v), .den(w_den),
    .side_in(w_side), .out_valid(d_valid), .q(d_q), .side_out(d_side)
  );

  // Select the result by region
  always_comb begin
    t_region = d_side[1:0];
    for (int c = 0; c < 3; c++) begin
      case (t_region)
        REGION_PASS:  t_chan[c] = RES_W'(d_side[2 + (3+c)*CB +: CB]);
        REGION_COPY:  t_chan[c] = RES_W'(d_side[2 + c*CB +: CB]);
        default:      t_chan[c] = RES_W'(d_q[c]);
      endcase
    end
    tail = {t_chan[2], t_chan[1], t_chan[0], t_region};
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || d_valid;
      skid_valid <= 1'b0;
    end else if (en && d_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_data <= skid_valid ? skid_data : tail;
    end else if (en && d_valid) begin
      skid_data <= tail;
    end
  end

  assign result.valid        = out_valid;
  assign result.region_code  = out_data[1:0];
  assign result.result_red   = out_data[2 +: RES_W];
  assign result.result_green = out_data[2 + RES_W +: RES_W];
  assign result.result_blue  = out_data[2 + 2*RES_W +: RES_W];

endmodule

// ----- hw/rtl/fsb_checker.sv -----
module fsb_checker import fsb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input region_t          region_code,
  input logic [RES_W-1:0] red,
  input logic [RES_W-1:0] green,
  input logic [RES_W-1:0] blue
);

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({red, green, blue, region_code}))
    else $error("result changed while stalled");

  // Region code is one of the three defined regions
  a_region: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (region_code == REGION_PASS || region_code == REGION_COPY ||
                   region_code == REGION_BLEND))
    else $error("undefined region code");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind feathered_spot_blend_unit fsb_checker u_fsb_checker (
  .clk(clk), .rst(rst),
  .out_valid(result.valid), .out_ready(result.ready),
  .region_code(result.region_code),
  .red(result.result_red), .green(result.result_green), .blue(result.result_blue)
);

// ----- test/fsb_blend_checker.sv -----
`timescale 1ns / 100ps

module fsb_blend_checker import fsb_pkg::*; (
  input  logic clk,
  input  logic rst,
  fsb_cfg_if   cfg,
  fsb_pixel_if pixel,
  fsb_result_if result,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    region_t     region;
  } blend_t;

  blend_t      blend_queue[$];
  logic [13:0] inner_r;
  logic [13:0] feather_r;

  // Integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned axis_sq(longint unsigned off, longint unsigned ctr);
    longint unsigned pos;
    longint unsigned d;
    pos = off * 16;
    d = (pos >= ctr) ? pos - ctr : ctr - pos;
    return d * d;
  endfunction

  function automatic logic [15:0] mix_chan(longint unsigned s, longint unsigned t,
                                           longint unsigned num, longint unsigned den);
    longint unsigned v;
    v = t * (den - num) + s * num + den / 2;
    return 16'(v / den);
  endfunction

  // Work out the blended pixel for one transaction
  function automatic blend_t blend_pixel(logic [10:0] ox, logic [10:0] oy,
                                         logic [47:0] src, logic [47:0] dst);
    blend_t b;
    longint unsigned f;
    longint unsigned ri;
    longint unsigned d2;
    longint unsigned rq;
    longint unsigned num;
    longint unsigned den;
    f = feather_r;
    ri = inner_r;
    d2 = axis_sq(ox, f) + axis_sq(oy, f);
    if (d2 >= f * f) begin
      {b.red, b.green, b.blue} = dst;
      b.region = REGION_PASS;
    end else if (d2 <= ri * ri) begin
      {b.red, b.green, b.blue} = src;
      b.region = REGION_COPY;
    end else begin
      rq = isqrt(d2 << 16);
      num = (f * 256 > rq) ? f * 256 - rq : 0;
      den = (f > ri) ? (f - ri) * 256 : 1;
      if (num > den) num = den;
      b.red = mix_chan(src[47:32], dst[47:32], num, den);
      b.green = mix_chan(src[31:16], dst[31:16], num, den);
      b.blue = mix_chan(src[15:0], dst[15:0], num, den);
      b.region = REGION_BLEND;
    end
    return b;
  endfunction

  assign pending_count = blend_queue.size();

  // Track registers, predict and compare
  always @(posedge clk) begin
    blend_t exp_b;
    if (rst) begin
      inner_r <= '0;
      feather_r <= '0;
      fail_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_INNER) inner_r <= cfg.data;
        else if (cfg.index == REG_FEATHER) feather_r <= cfg.data;
      end
      if (pixel.valid && pixel.ready)
        blend_queue = {blend_queue, blend_pixel(pixel.offset_x, pixel.offset_y,
          {pixel.source_red, pixel.source_green, pixel.source_blue},
          {pixel.target_red, pixel.target_green, pixel.target_blue})};
      if (result.valid && result.ready) begin
        if (blend_queue.size() == 0) begin
          $error("result transaction with no expectation");
          fail_count <= fail_count + 1;
        end else begin
          exp_b = blend_queue.pop_front();
          if (result.result_red !== exp_b.red ||
              result.result_green !== exp_b.green ||
              result.result_blue !== exp_b.blue ||
              result.region_code !== exp_b.region)
            fail_count <= fail_count + 1;
          if (result.result_red !== exp_b.red)
            $error("result_red expected %0d actual %0d", exp_b.red, result.result_red);
          if (result.result_green !== exp_b.green)
            $error("result_green expected %0d actual %0d", exp_b.green,
                   result.result_green);
          if (result.result_blue !== exp_b.blue)
            $error("result_blue expected %0d actual %0d", exp_b.blue, result.result_blue);
          if (result.region_code !== exp_b.region)
            $error("region_code expected %0d actual %0d", exp_b.region,
                   result.region_code);
        end
      end
    end
  end

endmodule

// ----- test/tb_feathered_spot_blend_unit.sv -----
`timescale 1ns / 100ps

module tb_feathered_spot_blend_unit;
  import fsb_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;

  fsb_cfg_if    cfg_bus();
  fsb_pixel_if  pixel_bus();
  fsb_result_if result_bus();

  feathered_spot_blend_unit DUT (
    .clk(clk), .rst(rst), .cfg(cfg_bus), .pixel(pixel_bus), .result(result_bus)
  );

  fsb_blend_checker checker_inst (
    .clk(clk), .rst(rst), .cfg(cfg_bus), .pixel(pixel_bus), .result(result_bus),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #2 clk = ~clk;

  // Stop at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 2);
  endfunction

  // Receiver stalls, with calm stretches
  initial begin
    int stall;
    result_bus.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if ($urandom_range(0, 3) == 0) stall = 0;
      else stall = gap_len();
      result_bus.ready <= 1'b0;
      repeat (stall) @(posedge clk);
      result_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [10:0] ox, logic [10:0] oy, logic [47:0] src,
                            logic [47:0] dst, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.offset_x <= ox;
    pixel_bus.offset_y <= oy;
    {pixel_bus.source_red, pixel_bus.source_green, pixel_bus.source_blue} <= src;
    {pixel_bus.target_red, pixel_bus.target_green, pixel_bus.target_blue} <= dst;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
  endtask

  task automatic drain();
    pixel_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_rgb();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // Offset near the spot, in pixels
  function automatic logic [10:0] near_offset(logic [13:0] f);
    int span;
    span = (f >> 3) + 2;
    if ($urandom_range(0, 15) == 0) return 11'($urandom);
    return 11'($urandom_range(0, span > 2047 ? 2047 : span));
  endfunction

  logic [13:0] inner_set[8] = '{0, 40, 0, 16383, 100, 16383, 300, 8};
  logic [13:0] feather_set[8] = '{0, 160, 16383, 16383, 800, 50, 200, 24};

  initial begin
    bit calm;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pixel_bus.valid = 1'b0;
    pixel_bus.offset_x = '0;
    pixel_bus.offset_y = '0;
    {pixel_bus.source_red, pixel_bus.source_green, pixel_bus.source_blue} = '0;
    {pixel_bus.target_red, pixel_bus.target_green, pixel_bus.target_blue} = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero feather after reset: everything passes through
    send_pixel(0, 0, '1, '0, 1'b0);
    send_pixel(11'h7FF, 11'h7FF, '0, '1, 1'b0);
    drain();

    // Directed: extremes of fields and regions
    write_reg(REG_INNER, 14'd40);
    write_reg(REG_FEATHER, 14'd160);
    send_pixel(10, 10, '1, '0, 1'b0);
    send_pixel(10, 10, '0, '1, 1'b0);
    send_pixel(13, 10, '1, '0, 1'b0);
    send_pixel(10, 17, 48'h0000_FFFF_1234, 48'hFFFF_0000_ABCD, 1'b0);
    send_pixel(20, 10, '1, '0, 1'b0);
    send_pixel(0, 0, '1, '0, 1'b0);
    send_pixel(11'h7FF, 0, '1, '0, 1'b0);
    send_pixel(0, 11'h7FF, '0, '1, 1'b0);
    send_pixel(11'h7FF, 11'h7FF, '1, '0, 1'b0);
    send_pixel(18, 14, 48'hAAAA_5555_FFFF, 48'h5555_AAAA_0000, 1'b0);
    drain();
    // Inner beyond feather: copy inside, pass outside
    write_reg(REG_INNER, 14'd16383);
    write_reg(REG_FEATHER, 14'd50);
    send_pixel(3, 3, '1, '0, 1'b0);
    send_pixel(6, 3, '1, '0, 1'b0);
    send_pixel(7, 7, '0, '1, 1'b0);
    drain();

    // Random phases over several settings
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_INNER, inner_set[p]);
      write_reg(REG_FEATHER, feather_set[p]);
      for (int i = 0; i < 140; i++) begin
        calm = (i % 40) < 10;
        send_pixel(near_offset(feather_set[p]), near_offset(feather_set[p]),
                   rand_rgb(), rand_rgb(), calm);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
